### src/agcm_pkg.sv
// ---------------------------------------------------------------------------
// agcm_pkg
// Shared types, constants and round functions for the AES-GCM block.
// ---------------------------------------------------------------------------
`default_nettype none
package agcm_pkg;

  localparam int unsigned LENGTH_COUNT_BITS = 36;
  localparam int unsigned GHASH_DIGIT       = 4;
  localparam int unsigned GHASH_STEPS       = 128 / GHASH_DIGIT;
  localparam int unsigned GHASH_CNT_W       = $clog2(GHASH_STEPS);

  localparam logic [1:0] OP_AAD    = 2'd0;
  localparam logic [1:0] OP_TEXT   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [3:0] CFG_KEY0    = 4'd0;
  localparam logic [3:0] CFG_KEY1    = 4'd1;
  localparam logic [3:0] CFG_KEY2    = 4'd2;
  localparam logic [3:0] CFG_KEY3    = 4'd3;
  localparam logic [3:0] CFG_IV_UP   = 4'd4;
  localparam logic [3:0] CFG_IV_LO   = 4'd5;
  localparam logic [3:0] CFG_KEYSIZE = 4'd6;
  localparam logic [3:0] CFG_DIR     = 4'd7;

  localparam logic [7:0]   GF_POLY  = 8'he1;
  localparam logic [7:0]   AES_POLY = 8'h1b;

  typedef logic [LENGTH_COUNT_BITS-1:0] len_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_HASHKEY,
    ST_TAGMASK,
    ST_DISPATCH,
    ST_CTR,
    ST_GHASH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic         start;
    logic [127:0] blk;
  } aes_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? AES_POLY : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = SBOX[s[127-8*((((c+r)&3)*4)+r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127-32*c -: 8];
      a1  = s[119-32*c -: 8];
      a2  = s[111-32*c -: 8];
      a3  = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int b = 0; b < 16; b++) begin
      m[127-8*b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    end
    lead_mask = m;
  endfunction

  function automatic len_t sat_add(input len_t cnt, input logic [4:0] n);
    logic [LENGTH_COUNT_BITS:0] sum;
    sum = {1'b0, cnt} + {{(LENGTH_COUNT_BITS-4){1'b0}}, n};
    sat_add = sum[LENGTH_COUNT_BITS] ? {LENGTH_COUNT_BITS{1'b1}} : sum[LENGTH_COUNT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

### src/agcm_key_sched.sv
// ---------------------------------------------------------------------------
// agcm_key_sched
// Word-serial AES key expansion into a round-key table, one word per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module agcm_key_sched (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [255:0] key_i,
  input  wire logic [1:0]   key_size_i,
  output logic              done_o,
  output logic [3:0]        nrounds_o,
  input  wire logic [3:0]   rd_idx_i,
  output logic [127:0]      rd_key_o
);

  logic [127:0] rows_q [15];
  logic [31:0]  win_q [8];
  logic [31:0]  win_d [8];
  logic         busy_q, busy_d;
  logic [5:0]   idx_q, idx_d;
  logic [2:0]   mod_q, mod_d;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   nr_q, nr_d;
  logic [3:0]   nk_q, nk_d;
  logic         done_q, done_d;
  logic [1:0]   ks;
  logic [31:0]  tw, new_w, wr_w;
  logic [2:0]   old_sel;
  logic [5:0]   total;

  assign ks      = (key_size_i == 2'd3) ? 2'd2 : key_size_i;
  assign old_sel = 3'(4'd8 - nk_q);
  assign total   = {nr_q, 2'b00} + 6'd4;

  always_comb begin
    tw = win_q[7];
    if (mod_q == 3'd0) begin
      tw = {SBOX_l(tw[23:16]) ^ rc_q, SBOX_l(tw[15:8]), SBOX_l(tw[7:0]), SBOX_l(tw[31:24])};
    end else if (nk_q == 4'd8 && mod_q == 3'd4) begin
      tw = {SBOX_l(tw[31:24]), SBOX_l(tw[23:16]), SBOX_l(tw[15:8]), SBOX_l(tw[7:0])};
    end
    new_w = win_q[old_sel] ^ tw;
  end

  function automatic logic [7:0] SBOX_l(input logic [7:0] b);
    SBOX_l = agcm_pkg::SBOX[b];
  endfunction

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    mod_d  = mod_q;
    rc_d   = rc_q;
    nr_d   = nr_q;
    nk_d   = nk_q;
    done_d = 1'b0;
    win_d  = win_q;
    wr_w   = new_w;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      mod_d  = '0;
      rc_d   = 8'h01;
      nr_d   = 4'd10 + {1'b0, ks, 1'b0};
      nk_d   = 4'd4 + {1'b0, ks, 1'b0};
      for (int k = 0; k < 8; k++) begin
        win_d[k] = key_i[255-32*k -: 32];
      end
      for (int k = 0; k < 8; k++) begin
        if (k < 4) begin
          win_d[7-k] = key_i[255-32*(3-k) -: 32];
        end
      end
      if (ks == 2'd1) begin
        for (int k = 0; k < 6; k++) begin
          win_d[7-k] = key_i[255-32*(5-k) -: 32];
        end
      end else if (ks == 2'd2) begin
        for (int k = 0; k < 8; k++) begin
          win_d[k] = key_i[255-32*k -: 32];
        end
      end
    end else if (busy_q) begin
      if ({2'b00, idx_q} < {2'b00, nk_q, 2'b00} >> 2) begin
        wr_w = key_i[255-32*idx_q[2:0] -: 32];
      end else begin
        for (int k = 0; k < 7; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[7] = new_w;
        if (mod_q == 3'd0) begin
          rc_d = agcm_pkg::xtime(rc_q);
        end
        mod_d = (mod_q == 3'(nk_q - 4'd1)) ? 3'd0 : mod_q + 3'd1;
      end
      idx_d = idx_q + 6'd1;
      if (idx_q == total - 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
      mod_q  <= '0;
      rc_q   <= 8'h01;
      nr_q   <= 4'd10;
      nk_q   <= 4'd4;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
      mod_q  <= mod_d;
      rc_q   <= rc_d;
      nr_q   <= nr_d;
      nk_q   <= nk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (busy_q && !start_i) begin
      rows_q[idx_q[5:2]][{~idx_q[1:0], 5'b0} +: 32] <= wr_w;
    end
  end

  assign done_o    = done_q;
  assign nrounds_o = nr_q;
  assign rd_key_o  = rows_q[rd_idx_i];

endmodule
`default_nettype wire

### src/agcm_aes_core.sv
// ---------------------------------------------------------------------------
// agcm_aes_core
// Iterated AES encryption, one round per cycle from the round-key table.
// ---------------------------------------------------------------------------
`default_nettype none
module agcm_aes_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire agcm_pkg::aes_req_t req_i,
  input  wire logic [3:0]        nrounds_i,
  output logic [3:0]             rk_idx_o,
  input  wire logic [127:0]      rk_i,
  output logic                   done_o,
  output logic [127:0]           blk_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [3:0]   round_q, round_d;
  logic [127:0] st_q, st_d;
  logic [127:0] ss;

  assign rk_idx_o = req_i.start ? 4'd0 : round_q;
  assign ss       = agcm_pkg::sub_shift(st_q);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    round_d = round_q;
    st_d    = st_q;
    if (req_i.start) begin
      st_d    = req_i.blk ^ rk_i;
      round_d = 4'd1;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (round_q == nrounds_i) begin
        st_d   = ss ^ rk_i;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        st_d    = agcm_pkg::mix_columns(ss) ^ rk_i;
        round_d = round_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign done_o = done_q;
  assign blk_o  = st_q;

endmodule
`default_nettype wire

### src/agcm_ghash.sv
// ---------------------------------------------------------------------------
// agcm_ghash
// Digit-serial GF(2^128) multiply-accumulate, four multiplier bits a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module agcm_ghash (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         clear_i,
  input  wire logic [127:0] blk_i,
  input  wire logic [127:0] h_i,
  output logic              done_o,
  output logic [127:0]      acc_o
);

  localparam int unsigned CW = agcm_pkg::GHASH_CNT_W;

  logic         busy_q;
  logic         done_q;
  logic [CW-1:0] cnt_q;
  logic [127:0] acc_q, x_q, v_q, z_q;
  logic [127:0] x_n, v_n, z_n;

  always_comb begin
    x_n = x_q;
    v_n = v_q;
    z_n = z_q;
    for (int i = 0; i < agcm_pkg::GHASH_DIGIT; i++) begin
      if (x_n[127]) begin
        z_n = z_n ^ v_n;
      end
      v_n = {1'b0, v_n[127:1]} ^ (v_n[0] ? {agcm_pkg::GF_POLY, 120'b0} : 128'b0);
      x_n = {x_n[126:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (clear_i) begin
        acc_q <= '0;
      end
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(agcm_pkg::GHASH_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          acc_q  <= z_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= acc_q ^ blk_i;
      v_q <= h_i;
      z_q <= '0;
    end else begin
      x_q <= x_n;
      v_q <= v_n;
      z_q <= z_n;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

### src/aes_gcm_authenticated_cipher.sv
// ---------------------------------------------------------------------------
// aes_gcm_authenticated_cipher
// AES-GCM encrypt/decrypt with AAD, text and finish transactions.
// ---------------------------------------------------------------------------
// Input channel: operation, block and byte count, taken while in_stall_o is
// low. Output channel: text results and finish results (tag or verify flag),
// held in an output register until out_stall_i is low. AAD transactions and
// operation 3 give no result. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce. A text block with bytes
// runs the iterated AES round, then the four-bit-a-cycle GHASH multiplier;
// finish, and AAD with bytes before any text, run only the multiplier. A
// message's first transaction adds key expansion (one word a cycle) and two
// AES blocks. The next transaction is taken once the current one is done and
// its result, if any, is in the output register. Reset clears the message
// state and the output; the round keys are rebuilt on the first transaction.
// A stalled result holds; more transactions are taken until one has a result.
// ---------------------------------------------------------------------------
`default_nettype none
module aes_gcm_authenticated_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  input  wire logic [4:0]  byte_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_high_o,
  output logic [63:0]      out_low_o,
  output logic [4:0]       valid_bytes_o,
  output logic             result_kind_o,
  output logic             tag_ok_o
);

  localparam int unsigned LB = agcm_pkg::LENGTH_COUNT_BITS;

  agcm_pkg::state_e state_q, state_d;

  logic [63:0]  key_q [4];
  logic [63:0]  iv_up_q;
  logic [31:0]  iv_lo_q;
  logic [1:0]   ks_q;
  logic         dir_q;

  logic [1:0]   op_q;
  logic [127:0] blk_q;
  logic [4:0]   n_q;
  logic [127:0] h_q, tm_q;
  logic [31:0]  ctr_q, ctr_d;
  agcm_pkg::len_t aad_q, aad_d, txt_q, txt_d;
  logic         in_text_q, in_text_d;
  logic         keys_ready_q, keys_ready_d;

  logic [127:0] res_data_q, res_data_d;
  logic [4:0]   res_n_q, res_n_d;
  logic         res_kind_q, res_kind_d;
  logic         res_ok_q, res_ok_d;

  logic         out_valid_q;
  logic [127:0] out_data_q;
  logic [4:0]   out_n_q;
  logic         out_kind_q, out_ok_q;
  logic         out_load;

  logic         ks_start, ks_done;
  logic [3:0]   nrounds, rk_idx;
  logic [127:0] rk;
  agcm_pkg::aes_req_t aes_req;
  logic         aes_done;
  logic [127:0] aes_out;
  logic         gh_start, gh_clear, gh_done;
  logic [127:0] gh_blk, gh_acc;
  logic         h_load, tm_load;

  logic         in_acc;
  logic [4:0]   n_clamp;
  logic [127:0] mask, masked, ctext, tag;

  assign in_stall_o = (state_q != agcm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign n_clamp    = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
  assign mask       = agcm_pkg::lead_mask(n_q);
  assign masked     = blk_q & mask;
  assign ctext      = (masked ^ aes_out) & mask;
  assign tag        = gh_acc ^ tm_q;

  agcm_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ks_start),
    .key_i      ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_size_i (ks_q),
    .done_o     (ks_done),
    .nrounds_o  (nrounds),
    .rd_idx_i   (rk_idx),
    .rd_key_o   (rk)
  );

  agcm_aes_core u_aes_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (aes_req),
    .nrounds_i (nrounds),
    .rk_idx_o  (rk_idx),
    .rk_i      (rk),
    .done_o    (aes_done),
    .blk_o     (aes_out)
  );

  agcm_ghash u_ghash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gh_start),
    .clear_i (gh_clear),
    .blk_i   (gh_blk),
    .h_i     (h_q),
    .done_o  (gh_done),
    .acc_o   (gh_acc)
  );

  always_comb begin
    state_d      = state_q;
    ks_start     = 1'b0;
    aes_req      = '{start: 1'b0, blk: '0};
    gh_start     = 1'b0;
    gh_clear     = 1'b0;
    gh_blk       = masked;
    h_load       = 1'b0;
    tm_load      = 1'b0;
    out_load     = 1'b0;
    ctr_d        = ctr_q;
    aad_d        = aad_q;
    txt_d        = txt_q;
    in_text_d    = in_text_q;
    keys_ready_d = keys_ready_q;
    res_data_d   = res_data_q;
    res_n_d      = res_n_q;
    res_kind_d   = res_kind_q;
    res_ok_d     = res_ok_q;
    unique case (state_q)
      agcm_pkg::ST_IDLE: begin
        if (in_acc && operation_i != 2'd3) begin
          if (!keys_ready_q) begin
            ks_start = 1'b1;
            state_d  = agcm_pkg::ST_EXPAND;
          end else begin
            state_d = agcm_pkg::ST_DISPATCH;
          end
        end
      end
      agcm_pkg::ST_EXPAND: begin
        if (ks_done) begin
          aes_req = '{start: 1'b1, blk: '0};
          state_d = agcm_pkg::ST_HASHKEY;
        end
      end
      agcm_pkg::ST_HASHKEY: begin
        if (aes_done) begin
          h_load  = 1'b1;
          aes_req = '{start: 1'b1, blk: {iv_up_q, iv_lo_q, 32'd1}};
          state_d = agcm_pkg::ST_TAGMASK;
        end
      end
      agcm_pkg::ST_TAGMASK: begin
        if (aes_done) begin
          tm_load      = 1'b1;
          keys_ready_d = 1'b1;
          state_d      = agcm_pkg::ST_DISPATCH;
        end
      end
      agcm_pkg::ST_DISPATCH: begin
        priority if (op_q == agcm_pkg::OP_AAD) begin
          if (!in_text_q && n_q != 5'd0) begin
            gh_start = 1'b1;
            aad_d    = agcm_pkg::sat_add(aad_q, n_q);
            state_d  = agcm_pkg::ST_GHASH;
          end else begin
            state_d = agcm_pkg::ST_IDLE;
          end
        end else if (op_q == agcm_pkg::OP_TEXT) begin
          in_text_d  = 1'b1;
          res_data_d = '0;
          res_n_d    = n_q;
          res_kind_d = 1'b0;
          res_ok_d   = 1'b0;
          if (n_q != 5'd0) begin
            aes_req = '{start: 1'b1, blk: {iv_up_q, iv_lo_q, ctr_q}};
            state_d = agcm_pkg::ST_CTR;
          end else begin
            state_d = agcm_pkg::ST_OUT;
          end
        end else begin
          gh_start = 1'b1;
          gh_blk   = {64'(aad_q) << 3, 64'(txt_q) << 3};
          state_d  = agcm_pkg::ST_GHASH;
        end
      end
      agcm_pkg::ST_CTR: begin
        if (aes_done) begin
          res_data_d = ctext;
          gh_start   = 1'b1;
          gh_blk     = dir_q ? ctext : masked;
          ctr_d      = ctr_q + 32'd1;
          txt_d      = agcm_pkg::sat_add(txt_q, n_q);
          state_d    = agcm_pkg::ST_GHASH;
        end
      end
      agcm_pkg::ST_GHASH: begin
        if (gh_done) begin
          priority if (op_q == agcm_pkg::OP_AAD) begin
            state_d = agcm_pkg::ST_IDLE;
          end else if (op_q == agcm_pkg::OP_TEXT) begin
            state_d = agcm_pkg::ST_OUT;
          end else begin
            res_kind_d   = 1'b1;
            res_data_d   = dir_q ? tag : '0;
            res_n_d      = dir_q ? 5'd16 : 5'd0;
            res_ok_d     = !dir_q && (tag == blk_q);
            gh_clear     = 1'b1;
            ctr_d        = 32'd2;
            aad_d        = '0;
            txt_d        = '0;
            in_text_d    = 1'b0;
            keys_ready_d = 1'b0;
            state_d      = agcm_pkg::ST_OUT;
          end
        end
      end
      agcm_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = agcm_pkg::ST_IDLE;
        end
      end
      default: state_d = agcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= agcm_pkg::ST_IDLE;
      ctr_q        <= 32'd2;
      aad_q        <= '0;
      txt_q        <= '0;
      in_text_q    <= 1'b0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      iv_up_q <= '0;
      iv_lo_q <= '0;
      ks_q    <= '0;
      dir_q   <= 1'b1;
    end else begin
      state_q      <= state_d;
      ctr_q        <= ctr_d;
      aad_q        <= aad_d;
      txt_q        <= txt_d;
      in_text_q    <= in_text_d;
      keys_ready_q <= keys_ready_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          agcm_pkg::CFG_KEY0:    key_q[0] <= cfg_data_i;
          agcm_pkg::CFG_KEY1:    key_q[1] <= cfg_data_i;
          agcm_pkg::CFG_KEY2:    key_q[2] <= cfg_data_i;
          agcm_pkg::CFG_KEY3:    key_q[3] <= cfg_data_i;
          agcm_pkg::CFG_IV_UP:   iv_up_q  <= cfg_data_i;
          agcm_pkg::CFG_IV_LO:   iv_lo_q  <= cfg_data_i[31:0];
          agcm_pkg::CFG_KEYSIZE: ks_q     <= cfg_data_i[1:0];
          agcm_pkg::CFG_DIR:     dir_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= operation_i;
      blk_q <= {block_high_i, block_low_i};
      n_q   <= n_clamp;
    end
    if (h_load) begin
      h_q <= aes_out;
    end
    if (tm_load) begin
      tm_q <= aes_out;
    end
    res_data_q <= res_data_d;
    res_n_q    <= res_n_d;
    res_kind_q <= res_kind_d;
    res_ok_q   <= res_ok_d;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_n_q    <= res_n_q;
      out_kind_q <= res_kind_q;
      out_ok_q   <= res_ok_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_high_o    = out_data_q[127:64];
  assign out_low_o     = out_data_q[63:0];
  assign valid_bytes_o = out_n_q;
  assign result_kind_o = out_kind_q;
  assign tag_ok_o      = out_ok_q;

endmodule
`default_nettype wire

### src/agcm_checker.sv
// ---------------------------------------------------------------------------
// agcm_checker
// Port-level assertions for the AES-GCM block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module agcm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] out_high_o,
  input wire logic [63:0] out_low_o,
  input wire logic [4:0]  valid_bytes_o,
  input wire logic        result_kind_o,
  input wire logic        tag_ok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_high_o) && $stable(out_low_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i != 2'd3 |=> in_stall_o)
    else $error("transaction accepted without going busy");

  a_text_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> valid_bytes_o <= 5'd16 && !tag_ok_o)
    else $error("bad text result");

  a_verify_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o && valid_bytes_o == 5'd0 |-> out_high_o == 64'd0 &&
    out_low_o == 64'd0)
    else $error("verify result carries data");

  a_tag_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tag_ok_o |-> result_kind_o && valid_bytes_o == 5'd0)
    else $error("tag_ok outside verify result");

endmodule

bind aes_gcm_authenticated_cipher agcm_checker u_agcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_high_o    (out_high_o),
  .out_low_o     (out_low_o),
  .valid_bytes_o (valid_bytes_o),
  .result_kind_o (result_kind_o),
  .tag_ok_o      (tag_ok_o)
);
`default_nettype wire

### tb/gcm_checker.sv
// ---------------------------------------------------------------------------
// gcm_checker
// Watches the configuration port and both channels of the AES-GCM block,
// predicts every text and finish result, and compares in order.
// ---------------------------------------------------------------------------
`default_nettype none
module gcm_checker
  import agcm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [3:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  input  wire logic         in_stall_i,
  input  wire logic [1:0]   operation_i,
  input  wire logic [63:0]  block_high_i,
  input  wire logic [63:0]  block_low_i,
  input  wire logic [4:0]   byte_count_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_stall_i,
  input  wire logic [63:0]  out_high_i,
  input  wire logic [63:0]  out_low_i,
  input  wire logic [4:0]   valid_bytes_i,
  input  wire logic         result_kind_i,
  input  wire logic         tag_ok_i,
  output int                fail_count_o,
  output int                pending_o,
  output logic [127:0]      computed_tag_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct {
    logic [127:0] data;
    logic [4:0]   nbytes;
    logic         kind;
    logic         ok;
  } gcm_result_t;

  gcm_result_t expected_results[$];

  logic [7:0]   sbox_tbl [256];
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_up_reg;
  logic [31:0]  iv_lo_reg;
  logic [1:0]   key_size_reg;
  logic         dir_reg;

  logic [7:0]   sched [240];
  int unsigned  rounds;
  logic [127:0] hkey;
  logic [127:0] jmask;
  logic [127:0] hash_acc;
  logic [31:0]  ctr;
  len_t         aad_len;
  len_t         text_len;
  logic         in_text;
  logic         keys_ready;

  assign pending_o = expected_results.size();

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = xt(a);
      b = b >> 1;
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
      sbox_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  function automatic logic [127:0] keep_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int b = 0; b < 16; b++) m[127-8*b -: 8] = (b < n) ? 8'hff : 8'h00;
    return m;
  endfunction

  function automatic len_t len_add(input len_t cnt, input logic [4:0] n);
    logic [LENGTH_COUNT_BITS:0] sum;
    sum = {1'b0, cnt} + (LENGTH_COUNT_BITS+1)'(n);
    return sum[LENGTH_COUNT_BITS] ? '1 : sum[LENGTH_COUNT_BITS-1:0];
  endfunction

  task automatic expand_schedule();
    int unsigned ks, nk, total;
    logic [7:0] t[4];
    logic [7:0] rc, k0;
    ks = (key_size_reg > 2) ? 2 : key_size_reg;
    nk = 4 + 2 * ks;
    rounds = 10 + 2 * ks;
    total = 4 * (rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < 240; i++) sched[i] = 8'h00;
    for (int i = 0; i < 4 * nk; i++)
      sched[i] = key_reg[(i >> 3) & 3][63-8*(i & 7) -: 8];
    for (int i = nk; i < total; i++) begin
      for (int j = 0; j < 4; j++) t[j] = sched[(i-1)*4+j];
      if (i % nk == 0) begin
        k0 = t[0];
        t[0] = sbox_tbl[t[1]] ^ rc;
        t[1] = sbox_tbl[t[2]];
        t[2] = sbox_tbl[t[3]];
        t[3] = sbox_tbl[k0];
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) t[j] = sbox_tbl[t[j]];
      end
      for (int j = 0; j < 4; j++) sched[i*4+j] = sched[(i-nk)*4+j] ^ t[j];
    end
  endtask

  function automatic logic [127:0] cipher_block(input logic [127:0] blk);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ sched[i];
    for (int r = 1; r <= rounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) t[c*4+q] = sbox_tbl[s[((c+q)&3)*4+q]];
      if (r < rounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ all ^ xt(a0 ^ a1);
          t[c*4+1] = a1 ^ all ^ xt(a1 ^ a2);
          t[c*4+2] = a2 ^ all ^ xt(a2 ^ a3);
          t[c*4+3] = a3 ^ all ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ sched[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic hash_in(input logic [127:0] blk);
    logic [127:0] x, v, z;
    x = hash_acc ^ blk;
    v = hkey;
    z = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z = z ^ v;
      v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
    end
    hash_acc = z;
  endtask

  task automatic clear_message();
    hash_acc = '0;
    ctr = 32'd2;
    aad_len = '0;
    text_len = '0;
    in_text = 1'b0;
    keys_ready = 1'b0;
  endtask

  task automatic predict_transaction(input logic [1:0] op, input logic [127:0] blk,
                                     input logic [4:0] cnt);
    logic [4:0] n;
    logic [127:0] m, o, tag;
    gcm_result_t r;
    n = (cnt > 16) ? 5'd16 : cnt;
    if (op == 2'd3) return;
    if (!keys_ready) begin
      expand_schedule();
      hkey = cipher_block('0);
      jmask = cipher_block({iv_up_reg, iv_lo_reg, 32'd1});
      keys_ready = 1'b1;
    end
    m = keep_mask(n);
    if (op == OP_AAD) begin
      if (!in_text && n > 0) begin
        hash_in(blk & m);
        aad_len = len_add(aad_len, n);
      end
    end else if (op == OP_TEXT) begin
      in_text = 1'b1;
      o = '0;
      if (n > 0) begin
        blk = blk & m;
        o = (blk ^ cipher_block({iv_up_reg, iv_lo_reg, ctr})) & m;
        hash_in(dir_reg ? o : blk);
        ctr = ctr + 32'd1;
        text_len = len_add(text_len, n);
      end
      r.data = o; r.nbytes = n; r.kind = KIND_TEXT; r.ok = 1'b0;
      expected_results.push_back(r);
    end else begin
      hash_in({25'd0, aad_len, 3'd0, 25'd0, text_len, 3'd0});
      tag = hash_acc ^ jmask;
      computed_tag_o = tag;
      r.kind = KIND_FINISH;
      if (dir_reg) begin
        r.data = tag; r.nbytes = 5'd16; r.ok = 1'b0;
      end else begin
        r.data = '0; r.nbytes = 5'd0; r.ok = (tag == blk);
      end
      expected_results.push_back(r);
      clear_message();
    end
  endtask

  task automatic report(input string field, input logic [127:0] got,
                        input logic [127:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  initial computed_tag_o = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    gcm_result_t w;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      iv_up_reg = '0;
      iv_lo_reg = '0;
      key_size_reg = '0;
      dir_reg = 1'b1;
      rounds = 10;
      clear_message();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $realtime, {out_high_i, out_low_i});
          fail_count_o++;
        end else begin
          w = expected_results.pop_front();
          if ({out_high_i, out_low_i} != w.data) report("data", {out_high_i, out_low_i}, w.data);
          if (valid_bytes_i != w.nbytes) report("valid_bytes", 128'(valid_bytes_i), 128'(w.nbytes));
          if (result_kind_i != w.kind) report("result_kind", 128'(result_kind_i), 128'(w.kind));
          if (tag_ok_i != w.ok) report("tag_ok", 128'(tag_ok_i), 128'(w.ok));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_reg[cfg_idx_i[1:0]] = cfg_data_i;
          CFG_IV_UP:   iv_up_reg = cfg_data_i;
          CFG_IV_LO:   iv_lo_reg = cfg_data_i[31:0];
          CFG_KEYSIZE: key_size_reg = cfg_data_i[1:0];
          CFG_DIR:     dir_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        predict_transaction(operation_i, {block_high_i, block_low_i}, byte_count_i);
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the AES-GCM block: directed messages over the corner cases,
// then random messages under three idling profiles and a long output
// hold-off. Checking is done by gcm_checker.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import agcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ITEM_TARGET = 1550;
  localparam int  IDLE_GAP    = 300;
  localparam int  HOLD_CYCLES = 600;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [63:0] DIR_DECRYPT = 64'd0;
  localparam logic [63:0] DIR_ENCRYPT = 64'd1;
  localparam logic [63:0] KS_128 = 64'd0;
  localparam logic [63:0] KS_256 = 64'd2;
  localparam logic [63:0] KS_ALIAS = 64'd3;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
  } gcm_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic [4:0] byte_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [63:0] out_high_o;
  logic [63:0] out_low_o;
  logic [4:0] valid_bytes_o;
  logic result_kind_o;
  logic tag_ok_o;

  int fail_count;
  int pending;
  logic [127:0] computed_tag;

  int tx_idle = 31;
  int rx_idle = 84;
  logic hold_out = 1'b0;
  int sent = 0;
  logic dir_now = 1'b1;
  gcm_item_t msg[$];

  always #5 clk_i = ~clk_i;

  aes_gcm_authenticated_cipher u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .block_high_i, .block_low_i,
    .byte_count_i, .out_valid_o, .out_stall_i, .out_high_o, .out_low_o,
    .valid_bytes_o, .result_kind_o, .tag_ok_o
  );

  gcm_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .block_high_i,
    .block_low_i, .byte_count_i, .out_valid_i(out_valid_o), .out_stall_i,
    .out_high_i(out_high_o), .out_low_i(out_low_o), .valid_bytes_i(valid_bytes_o),
    .result_kind_i(result_kind_o), .tag_ok_i(tag_ok_o),
    .fail_count_o(fail_count), .pending_o(pending), .computed_tag_o(computed_tag)
  );

  always @(negedge clk_i) begin
    out_stall_i = hold_out || ($urandom_range(99) < rx_idle);
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send(input gcm_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = it.op;
    block_high_i = it.hi;
    block_low_i = it.lo;
    byte_count_i = it.cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (it.op != OP_NONE) sent++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) send(msg[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_DIR) dir_now = data[0];
  endtask

  task automatic add(input logic [1:0] op, input logic [63:0] hi, input logic [63:0] lo,
                     input logic [4:0] cnt);
    gcm_item_t it;
    it.op = op; it.hi = hi; it.lo = lo; it.cnt = cnt;
    msg.push_back(it);
  endtask

  task automatic replay_with_tag(input logic corrupt);
    gcm_item_t last;
    wait_idle();
    last = msg.pop_back();
    {last.hi, last.lo} = computed_tag ^ (corrupt ? (128'd1 << $urandom_range(127)) : '0);
    msg.push_back(last);
    send_msg();
  endtask

  task automatic build_random();
    int naad, ntext;
    msg.delete();
    naad = $urandom_range(0, 3);
    ntext = $urandom_range(0, 8);
    for (int k = 0; k < naad; k++)
      add(OP_AAD, rnd64(), rnd64(),
          (k == naad - 1 && $urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16);
    for (int k = 0; k < ntext; k++) begin
      if ($urandom_range(9) == 0) add(OP_NONE, rnd64(), rnd64(), 5'($urandom));
      if (k > 0 && $urandom_range(9) == 0) add(OP_AAD, rnd64(), rnd64(), 5'($urandom));
      add(OP_TEXT, rnd64(), rnd64(),
          (k == ntext - 1 && $urandom_range(3) == 0) || $urandom_range(19) == 0 ?
          5'($urandom_range(31)) : 5'd16);
    end
    add(OP_FINISH, rnd64(), rnd64(), 5'($urandom));
  endtask

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    msg.delete();
    add(OP_FINISH, '0, '0, 5'd0);
    add(OP_AAD, '1, '1, 5'd16);
    add(OP_AAD, '1, '1, 5'd0);
    add(OP_AAD, rnd64(), rnd64(), 5'd5);
    add(OP_NONE, '1, '1, 5'd31);
    add(OP_TEXT, '1, '1, 5'd16);
    add(OP_TEXT, '1, '1, 5'd0);
    add(OP_TEXT, rnd64(), rnd64(), 5'd31);
    add(OP_TEXT, rnd64(), rnd64(), 5'd7);
    add(OP_AAD, rnd64(), rnd64(), 5'd16);
    add(OP_TEXT, '0, '0, 5'd16);
    send_msg();
    wait_idle();
    cfg_write(CFG_IV_LO, '1);
    msg.delete();
    add(OP_TEXT, rnd64(), rnd64(), 5'd9);
    add(OP_FINISH, '1, '1, 5'd16);
    send_msg();
    wait_idle();

    for (int i = 0; i < 4; i++) cfg_write(4'(i), '1);
    cfg_write(CFG_IV_UP, '1);
    cfg_write(CFG_KEYSIZE, KS_256);
    cfg_write(CFG_DIR, DIR_DECRYPT);
    cfg_write(4'd9, '1);
    cfg_write(4'd15, '0);
    msg.delete();
    add(OP_AAD, rnd64(), rnd64(), 5'd16);
    add(OP_TEXT, rnd64(), rnd64(), 5'd16);
    add(OP_TEXT, rnd64(), rnd64(), 5'd3);
    add(OP_FINISH, rnd64(), rnd64(), 5'd16);
    send_msg();
    replay_with_tag(1'b0);
    wait_idle();
    cfg_write(CFG_KEYSIZE, KS_ALIAS);
    cfg_write(CFG_DIR, DIR_ENCRYPT);
    msg.delete();
    add(OP_TEXT, rnd64(), rnd64(), 5'd16);
    add(OP_FINISH, '0, '0, 5'd0);
    send_msg();

    while (sent < ITEM_TARGET) begin
      wait_idle();
      if (sent < ITEM_TARGET * 2 / 5) begin
        tx_idle = 31; rx_idle = 84;
      end else if (sent < ITEM_TARGET * 3 / 4) begin
        tx_idle = 84; rx_idle = 31;
      end else begin
        if (tx_idle != 0) begin
          fork
            begin
              hold_out = 1'b1;
              repeat (HOLD_CYCLES) @(negedge clk_i);
              hold_out = 1'b0;
            end
          join_none
        end
        tx_idle = 0; rx_idle = 0;
      end
      if ($urandom_range(2) == 0) begin
        for (int i = 0; i < 4; i++)
          cfg_write(4'(i), $urandom_range(7) == 0 ? {64{1'($urandom)}} : rnd64());
        cfg_write(CFG_IV_UP, rnd64());
        cfg_write(CFG_IV_LO, rnd64());
        cfg_write(CFG_KEYSIZE, $urandom_range(3) == 0 ? rnd64() : (rnd64() & ~64'd3) | KS_128);
      end
      cfg_write(CFG_DIR, rnd64());
      build_random();
      send_msg();
      if (!dir_now && $urandom_range(1) == 0) replay_with_tag($urandom_range(3) == 0);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
